// File: src/ctrfd_pkg.sv
`timescale 1ns / 1ps

package ctrfd_pkg;

    // Input opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_NULL = 2'd2;

    // Characters of the COPY text format.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_PEND = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [5:0] field_index;
        phase_t     phase;
        logic       field_has_bytes;
        logic       line_has_bytes;
        logic       discarding;
        logic       padding;
    } ctrfd_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } ctrfd_res_t;

endpackage

// File: src/copy_text_row_field_decoder.sv
`timescale 1ns / 1ps
// Accepted items are registered; results go to a separate output register.
// Throughput: one item per cycle while it gives at most one result and the
// single result register is free; an item with two results, or an end of line
// with up to one plus the column count of results, is held until each is loaded.
// Reset: asynchronous, active low; clears row state and sets column_count to 1.
module copy_text_row_field_decoder
#(
    parameter int MAX_COLUMNS = 60
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       opcode,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last_column
);
    import ctrfd_pkg::*;

    localparam logic [5:0] MaxCols = 6'(MAX_COLUMNS);

    logic [5:0]   column_count_reg;
    logic [5:0]   eff_count;
    logic         item_valid_reg;
    logic         item_op_reg;
    logic [7:0]   item_byte_reg;
    ctrfd_state_t state_reg;
    ctrfd_state_t state_next;
    ctrfd_res_t   step_res;
    logic         step_emit;
    logic         step_done;
    logic         out_free;
    logic         proceed;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (column_count_reg == 6'd0)
            eff_count = 6'd1;
        else if (column_count_reg > MaxCols)
            eff_count = MaxCols;
        else
            eff_count = column_count_reg;
    end

    ctrfd_step u_step
    (
        .st        (state_reg),
        .opcode    (item_op_reg),
        .data_byte (item_byte_reg),
        .num_cols  (eff_count),
        .nxt       (state_next),
        .emit      (step_emit),
        .res       (step_res),
        .done      (step_done)
    );

    assign proceed    = item_valid_reg && (!step_emit || out_free);
    assign byte_stall = item_valid_reg && !(proceed && step_done);

    ctrfd_out_reg u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (proceed && step_emit),
        .res         (step_res),
        .res_stall   (res_stall),
        .free        (out_free),
        .res_valid   (res_valid),
        .kind        (kind),
        .out_byte    (out_byte),
        .last_column (last_column)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 6'd1;
            item_valid_reg   <= 1'b0;
            state_reg        <= '{field_index: 6'd0, phase: PH_NONE, field_has_bytes: 1'b0,
                                  line_has_bytes: 1'b0, discarding: 1'b0, padding: 1'b0};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                column_count_reg <= cfg_data;
            if (byte_valid && !byte_stall)
                item_valid_reg <= 1'b1;
            else if (proceed && step_done)
                item_valid_reg <= 1'b0;
            if (proceed)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_op_reg   <= opcode;
            item_byte_reg <= data_byte;
        end
    end

endmodule

// File: src/ctrfd_step.sv
`timescale 1ns / 1ps

module ctrfd_step
(
    input  ctrfd_pkg::ctrfd_state_t st,
    input  logic                    opcode,
    input  logic [7:0]              data_byte,
    input  logic [5:0]              num_cols,
    output ctrfd_pkg::ctrfd_state_t nxt,
    output logic                    emit,
    output ctrfd_pkg::ctrfd_res_t   res,
    output logic                    done
);
    import ctrfd_pkg::*;

    logic       last_fi;
    logic [5:0] fi_inc;

    assign last_fi = ({1'b0, st.field_index} + 7'd1) >= {1'b0, num_cols};
    assign fi_inc  = st.field_index + 6'd1;

    // One step emits at most one result. An item that needs two results takes
    // a second step on the same item, starting from the state the first left.
    always_comb
    begin
        nxt  = st;
        emit = 1'b0;
        res  = '{kind: KIND_DATA, data: 8'h00, last: 1'b0};
        done = 1'b1;
        if (opcode == OP_BYTE)
        begin
            nxt.line_has_bytes = 1'b1;
            if (!st.discarding)
            begin
                case (st.phase)
                    PH_HELD:
                    begin
                        if (data_byte == CH_TAB)
                        begin
                            emit                = 1'b1;
                            res                 = '{kind: KIND_NULL, data: 8'h00, last: last_fi};
                            nxt.field_index     = fi_inc;
                            nxt.discarding      = last_fi;
                            nxt.phase           = PH_NONE;
                            nxt.field_has_bytes = 1'b0;
                        end
                        else
                        begin
                            emit                = 1'b1;
                            res.data            = CH_UP_N;
                            nxt.phase           = PH_NONE;
                            nxt.field_has_bytes = 1'b1;
                            done                = 1'b0;
                        end
                    end
                    PH_PEND:
                    begin
                        if (data_byte == CH_TAB)
                        begin
                            // The lone backslash goes out first, then the tab
                            // is handled on the next step as a plain tab.
                            emit                = 1'b1;
                            res.data            = CH_BSL;
                            nxt.phase           = PH_NONE;
                            nxt.field_has_bytes = 1'b1;
                            done                = 1'b0;
                        end
                        else if (data_byte == CH_UP_N && !st.field_has_bytes)
                        begin
                            nxt.phase = PH_HELD;
                        end
                        else
                        begin
                            emit                = 1'b1;
                            nxt.phase           = PH_NONE;
                            nxt.field_has_bytes = 1'b1;
                            if (data_byte == CH_LO_N)
                                res.data = CH_LF;
                            else if (data_byte == CH_LO_R)
                                res.data = CH_CR;
                            else if (data_byte == CH_LO_T)
                                res.data = CH_TAB;
                            else
                                res.data = data_byte;
                        end
                    end
                    default:
                    begin
                        if (data_byte == CH_TAB)
                        begin
                            emit                = 1'b1;
                            res                 = '{kind: KIND_END, data: 8'h00, last: last_fi};
                            nxt.field_index     = fi_inc;
                            nxt.discarding      = last_fi;
                            nxt.phase           = PH_NONE;
                            nxt.field_has_bytes = 1'b0;
                        end
                        else if (data_byte == CH_BSL)
                        begin
                            nxt.phase = PH_PEND;
                        end
                        else
                        begin
                            emit                = 1'b1;
                            res.data            = data_byte;
                            nxt.field_has_bytes = 1'b1;
                        end
                    end
                endcase
            end
        end
        else
        begin
            if (st.padding)
            begin
                emit            = 1'b1;
                res             = '{kind: KIND_NULL, data: 8'h00, last: last_fi};
                nxt.field_index = fi_inc;
                done            = last_fi;
            end
            else if (st.line_has_bytes && !st.discarding)
            begin
                if (st.phase == PH_PEND)
                begin
                    emit                = 1'b1;
                    res.data            = CH_BSL;
                    nxt.phase           = PH_NONE;
                    nxt.field_has_bytes = 1'b1;
                    done                = 1'b0;
                end
                else
                begin
                    emit                = 1'b1;
                    res.kind            = (st.phase == PH_HELD) ? KIND_NULL : KIND_END;
                    res.last            = last_fi;
                    nxt.field_index     = fi_inc;
                    nxt.phase           = PH_NONE;
                    nxt.field_has_bytes = 1'b0;
                    nxt.padding         = 1'b1;
                    done                = last_fi;
                end
            end
            // The end of a line clears all row state once its results are out.
            if (done)
                nxt = '{field_index: 6'd0, phase: PH_NONE, field_has_bytes: 1'b0,
                        line_has_bytes: 1'b0, discarding: 1'b0, padding: 1'b0};
        end
    end

endmodule

// File: src/ctrfd_out_reg.sv
`timescale 1ns / 1ps

module ctrfd_out_reg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  ctrfd_pkg::ctrfd_res_t res,
    input  logic                  res_stall,
    output logic                  free,
    output logic                  res_valid,
    output logic [1:0]            kind,
    output logic [7:0]            out_byte,
    output logic                  last_column
);
    import ctrfd_pkg::*;

    logic       valid_reg;
    ctrfd_res_t res_reg;

    assign free        = !valid_reg || !res_stall;
    assign res_valid   = valid_reg;
    assign kind        = res_reg.kind;
    assign out_byte    = res_reg.data;
    assign last_column = res_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!res_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule
